FILE: rtl/kmp_pkg.sv
package kmp_pkg;

  // Pattern capacity and symbol width.
  localparam int MAX_PATTERN = 64;
  localparam int SYMBOL_BITS = 8;

  // Fixed field widths of the ports.
  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int ML_W   = 7;
  localparam int POS_W  = 32;
  localparam int STAT_W = 2;

  // Internal widths that follow from the pattern capacity.
  localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int FB_DEPTH = MAX_PATTERN + 1;

  // Symbol bits that take part in a compare.
  localparam logic [SYM_W-1:0] SYM_MASK =
      (SYMBOL_BITS >= SYM_W) ? {SYM_W{1'b1}} : SYM_W'((1 << SYMBOL_BITS) - 1);

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

  // Status codes on the result channel.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Input queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation class decided by the front.
  typedef enum logic [1:0] {
    OP_START,
    OP_APPEND,
    OP_TEXT,
    OP_IGNORE
  } op_t;

  // One queued beat.
  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } item_t;

  // Back-end sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

FILE: rtl/kmp_front.sv
module kmp_front import kmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [SYM_W-1:0] in_symbol,
  output logic             q_valid,
  output item_t            q_item,
  input  logic             q_pop
);

  item_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  item_t              in_item;
  logic               push;

  // Classify the incoming command and mask the symbol.
  always_comb begin
    in_item.sym = in_symbol & SYM_MASK;
    unique case (in_command)
      CMD_START:  in_item.op = OP_START;
      CMD_APPEND: in_item.op = OP_APPEND;
      CMD_TEXT:   in_item.op = OP_TEXT;
      default:    in_item.op = OP_IGNORE;
    endcase
  end

  // Queue handshake.
  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push  ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (!push && q_pop) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

FILE: rtl/kmp_back.sv
module kmp_back import kmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ML_W-1:0]   out_match_length,
  output logic              out_match_found,
  output logic [POS_W-1:0]  out_end_position,
  output logic [STAT_W-1:0] out_status
);

  // Pattern symbols and fallback lengths.
  logic [SYM_W-1:0] store_mem [MAX_PATTERN];
  logic [LEN_W-1:0] fb_mem    [FB_DEPTH];

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [LEN_W-1:0]  border_r, border_nxt;
  logic [LEN_W-1:0]  tml_r, tml_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  op_t               op_r, op_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ML_W-1:0]   out_ml_r, out_ml_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic [SYM_W-1:0]  rd_sym_r;
  logic [LEN_W-1:0]  rd_fb_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [LEN_W-1:0]  fb_raddr;
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [SYM_W-1:0]  st_wdata;
  logic              fb_we;
  logic [LEN_W-1:0]  fb_waddr;
  logic [LEN_W-1:0]  fb_wdata;

  logic              out_free;
  logic              plen_empty;
  logic              plen_full;
  logic              start_like;
  logic              walk_needed;
  logic              hit;
  logic              walk_done;
  logic [LEN_W-1:0]  k_fin;

  // Common conditions.
  assign out_free    = !out_valid_r || out_ready;
  assign plen_empty  = (plen_r == '0);
  assign plen_full   = (plen_r == LEN_W'(MAX_PATTERN));
  assign start_like  = (q_item.op == OP_START) || (q_item.op == OP_APPEND && plen_empty);
  assign walk_needed = (q_item.op == OP_APPEND && !plen_empty && !plen_full) ||
                       (q_item.op == OP_TEXT && !plen_empty);
  assign q_pop       = (state_r == ST_IDLE) && q_valid && out_free;

  // One fallback step: compare the symbol at the current length.
  assign hit       = (rd_sym_r == sym_r);
  assign walk_done = hit || (k_r == '0);
  assign k_fin     = hit ? LEN_W'(k_r + 1'b1) : '0;
  assign fb_raddr  = LEN_W'(rd_addr);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop && walk_needed) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory ports and result register.
  always_comb begin
    plen_nxt      = plen_r;
    border_nxt    = border_r;
    tml_nxt       = tml_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    op_nxt        = op_r;
    sym_nxt       = sym_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ml_nxt    = out_ml_r;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_stat_nxt  = out_stat_r;
    rd_addr       = k_r[IDX_W-1:0];
    st_we         = 1'b0;
    st_waddr      = plen_r[IDX_W-1:0];
    st_wdata      = sym_r;
    fb_we         = 1'b0;
    fb_waddr      = LEN_W'(plen_r + 1'b1);
    fb_wdata      = k_fin;

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          op_nxt        = q_item.op;
          sym_nxt       = q_item.sym;
          out_ml_nxt    = '0;
          out_found_nxt = 1'b0;
          out_pos_nxt   = pos_r;
          out_stat_nxt  = STAT_OK;
          priority if (start_like) begin
            // New one-symbol pattern; a start also clears the text state.
            st_we         = 1'b1;
            st_waddr      = '0;
            st_wdata      = q_item.sym;
            fb_we         = 1'b1;
            fb_waddr      = LEN_W'(1);
            fb_wdata      = '0;
            plen_nxt      = LEN_W'(1);
            border_nxt    = '0;
            out_valid_nxt = 1'b1;
            if (q_item.op == OP_START) begin
              tml_nxt     = '0;
              pos_nxt     = '0;
              out_pos_nxt = '0;
            end
          end else if (q_item.op == OP_APPEND && plen_full) begin
            out_valid_nxt = 1'b1;
            out_ml_nxt    = ML_W'(border_r);
            out_stat_nxt  = STAT_FULL;
          end else if (q_item.op == OP_APPEND) begin
            k_nxt   = border_r;
            rd_addr = border_r[IDX_W-1:0];
          end else if (q_item.op == OP_TEXT && plen_empty) begin
            out_valid_nxt = 1'b1;
            out_stat_nxt  = STAT_EMPTY;
          end else if (q_item.op == OP_TEXT) begin
            k_nxt   = tml_r;
            rd_addr = tml_r[IDX_W-1:0];
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (!walk_done) begin
          // Follow the fallback link and fetch the next compare.
          k_nxt   = rd_fb_r;
          rd_addr = rd_fb_r[IDX_W-1:0];
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_stat_nxt  = STAT_OK;
          out_pos_nxt   = pos_r;
          unique case (op_r)
            OP_APPEND: begin
              st_we      = 1'b1;
              fb_we      = 1'b1;
              plen_nxt   = LEN_W'(plen_r + 1'b1);
              border_nxt = k_fin;
              out_ml_nxt = ML_W'(k_fin);
            end
            OP_TEXT: begin
              pos_nxt     = POS_W'(pos_r + 1'b1);
              out_pos_nxt = POS_W'(pos_r + 1'b1);
              if (k_fin == plen_r) begin
                // Full match: resume from the pattern border.
                out_found_nxt = 1'b1;
                out_ml_nxt    = ML_W'(plen_r);
                tml_nxt       = border_r;
              end else begin
                out_ml_nxt = ML_W'(k_fin);
                tml_nxt    = k_fin;
              end
            end
            default: out_ml_nxt = '0;
          endcase
        end
      end
      default: out_valid_nxt = out_valid_r;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plen_r      <= '0;
      border_r    <= '0;
      tml_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      border_r    <= border_nxt;
      tml_r       <= tml_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    op_r        <= op_nxt;
    sym_r       <= sym_nxt;
    out_ml_r    <= out_ml_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // Pattern store with registered read.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    rd_sym_r <= store_mem[rd_addr];
  end

  // Fallback table with registered read.
  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    rd_fb_r <= fb_mem[fb_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_match_length = out_ml_r;
  assign out_match_found  = out_found_r;
  assign out_end_position = out_pos_r;
  assign out_status       = out_stat_r;

endmodule

FILE: rtl/kmp_stream_matcher.sv
// Streaming pattern matcher with online fallback-table construction.
// Input channel (in_valid/in_ready): each beat carries in_command and
// in_symbol. Command start loads a one-symbol pattern and clears the text
// position, append extends the pattern, text presents one text symbol.
// Result channel (out_valid/out_ready): exactly one result beat per input
// beat, in order, with the match length, a full-match flag, the count of
// text symbols consumed and a status code.
// Each accepted beat is held in the input queue until the back end takes
// it. Start, dropped, empty-pattern and unknown commands load the result
// register when the back end takes them. Append and text beats pass through
// the walk state, which follows one fallback link per compare until the
// symbol extends the match or the length is zero, then loads the result
// register once it is free; the registered read port of the pattern and
// fallback memories allows one link per cycle. A text run follows no more
// links than it consumes symbols; the input queue keeps accepting beats
// during a walk, and its two entries absorb longer fallback walks.
// Reset clears the pattern length, match state, position, the input queue and
// the result register; the memories are not cleared and are only read below
// the pattern length. When out_ready is low the result is held in the output
// register, the back end waits, and the input queue accepts until it is full.
module kmp_stream_matcher import kmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ML_W-1:0]   out_match_length,
  output logic              out_match_found,
  output logic [POS_W-1:0]  out_end_position,
  output logic [STAT_W-1:0] out_status
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Accept and classify beats.
  kmp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_symbol  (in_symbol),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Pattern build and text matching.
  kmp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_length (out_match_length),
    .out_match_found  (out_match_found),
    .out_end_position (out_end_position),
    .out_status       (out_status)
  );

endmodule

FILE: rtl/kmp_checker.sv
module kmp_checker import kmp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ML_W-1:0]   out_match_length,
  input logic              out_match_found,
  input logic [POS_W-1:0]  out_end_position,
  input logic [STAT_W-1:0] out_status
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_length) &&
      $stable(out_match_found) && $stable(out_end_position) && $stable(out_status))
    else $error("result beat changed while stalled");

  // A full match is reported with a good status and a nonzero length.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_found |-> out_status == STAT_OK && out_match_length != '0)
    else $error("match flagged with bad status or zero length");

  // An empty-pattern text beat reports no match.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_match_length == '0 && !out_match_found)
    else $error("empty-pattern result carries a match");

  // The match length never exceeds the pattern capacity.
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_match_length <= ML_W'(MAX_PATTERN))
    else $error("match length beyond capacity");

  // Reset empties the result register.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (.*);

FILE: tb/kmp_match_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the matcher, predicts one result per input beat
// and compares every result beat against the oldest prediction.
module kmp_match_checker import kmp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ML_W-1:0]   out_match_length,
  input  logic              out_match_found,
  input  logic [POS_W-1:0]  out_end_position,
  input  logic [STAT_W-1:0] out_status,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [ML_W-1:0]   match_length;
    logic              match_found;
    logic [POS_W-1:0]  end_position;
    logic [STAT_W-1:0] status;
  } match_result_t;

  // Shadow copy of the matcher state.
  logic [SYM_W-1:0]  pat_mem [0:MAX_PATTERN-1];
  logic [LEN_W-1:0]  fb_mem  [0:MAX_PATTERN];
  logic [LEN_W-1:0]  pat_len;
  logic [LEN_W-1:0]  pat_border;
  logic [LEN_W-1:0]  txt_len;
  logic [POS_W-1:0]  txt_pos;

  match_result_t expected_results [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Advances the shadow state by one input beat and returns its result.
  task automatic predict_match(input logic [CMD_W-1:0] cmd,
                               input logic [SYM_W-1:0] sym_in,
                               output match_result_t res);
    logic [SYM_W-1:0] sym;
    int k;
    sym = sym_in & SYM_MASK;
    res = '0;
    res.status = STAT_OK;
    if (cmd == CMD_START || (cmd == CMD_APPEND && pat_len == 0)) begin
      // A start, or an append to an empty pattern, loads a one-symbol pattern.
      pat_mem[0] = sym;
      fb_mem[0]  = '0;
      fb_mem[1]  = '0;
      pat_len    = LEN_W'(1);
      pat_border = '0;
      if (cmd == CMD_START) begin
        txt_len = '0;
        txt_pos = '0;
      end
    end else if (cmd == CMD_APPEND) begin
      if (pat_len >= MAX_PATTERN) begin
        res.status       = STAT_FULL;
        res.match_length = ML_W'(pat_border);
      end else begin
        // Extend the border of the pattern built so far.
        k = pat_border;
        while (k > 0 && pat_mem[k] != sym) k = fb_mem[k];
        if (pat_mem[k] == sym) k++;
        pat_mem[pat_len]    = sym;
        fb_mem[pat_len + 1] = LEN_W'(k);
        pat_len             = pat_len + 1'b1;
        pat_border          = LEN_W'(k);
        res.match_length    = ML_W'(k);
      end
    end else if (cmd == CMD_TEXT) begin
      if (pat_len == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        // Follow fallback links until the symbol extends the match.
        k = txt_len;
        while (k > 0 && k < MAX_PATTERN && pat_mem[k] != sym) k = fb_mem[k];
        if (k < pat_len && k < MAX_PATTERN && pat_mem[k] == sym) k++;
        txt_pos = txt_pos + 1'b1;
        if (k >= pat_len) begin
          res.match_found  = 1'b1;
          res.match_length = ML_W'(pat_len);
          k = pat_border;
        end else begin
          res.match_length = ML_W'(k);
        end
        txt_len = LEN_W'(k);
      end
    end
    res.end_position = txt_pos;
  endtask

  // Results are checked before new beats are predicted on the same edge.
  always @(posedge clk) begin
    match_result_t want;
    match_result_t got;
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < MAX_PATTERN; i++) pat_mem[i] = '0;
      for (int i = 0; i <= MAX_PATTERN; i++) fb_mem[i] = '0;
      pat_len    = '0;
      pat_border = '0;
      txt_len    = '0;
      txt_pos    = '0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_match_length, out_match_found, out_end_position, out_status};
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: match_length %0d, end_position %0d",
                 got.match_length, got.end_position);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.match_length !== want.match_length) begin
            $error("match_length: expected %0d, actual %0d", want.match_length,
                   got.match_length);
            errors++;
          end
          if (got.match_found !== want.match_found) begin
            $error("match_found: expected %0d, actual %0d", want.match_found,
                   got.match_found);
            errors++;
          end
          if (got.end_position !== want.end_position) begin
            $error("end_position: expected %0d, actual %0d", want.end_position,
                   got.end_position);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_match(in_command, in_symbol, want);
        expected_results.insert(expected_results.size(), want);
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/tb_kmp_stream_matcher.sv
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;
  import kmp_pkg::*;

  // The one command code the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int TOTAL_BEATS = 1050;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command = CMD_START;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ML_W-1:0]   out_match_length;
  logic              out_match_found;
  logic [POS_W-1:0]  out_end_position;
  logic [STAT_W-1:0] out_status;

  int errors;
  int pending;
  int beats_sent = 0;
  bit no_idle = 1'b0;

  always #10 clk = ~clk;

  kmp_stream_matcher DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_length (out_match_length),
    .out_match_found  (out_match_found),
    .out_end_position (out_end_position),
    .out_status       (out_status)
  );

  kmp_match_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_length (out_match_length),
    .out_match_found  (out_match_found),
    .out_end_position (out_end_position),
    .out_status       (out_status),
    .errors           (errors),
    .pending          (pending)
  );

  // Result side stalls at random, except inside the quiet window.
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 30);
    end
  end

  // Any command code at random, the unused one included.
  function automatic logic [CMD_W-1:0] CMD_CODE();
    return CMD_W'($urandom_range(3));
  endfunction

  // Presents one beat, with an optional random gap before it, and waits
  // until it is accepted.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
    no_idle = (beats_sent >= 500 && beats_sent < 700);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_symbol  <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // One pattern load followed by a text run over a small alphabet, so that
  // matches and fallback walks are frequent. Some noise beats are mixed in.
  task automatic run_pattern_session(input bit fill_pattern);
    logic [SYM_W-1:0] alpha [0:2];
    logic [SYM_W-1:0] pat_syms [0:79];
    int n_alpha;
    int plen;
    int tlen;
    int pick;
    for (int i = 0; i < 3; i++) alpha[i] = SYM_W'($urandom_range(255));
    n_alpha = $urandom_range(1, 3);
    if (fill_pattern) begin
      plen = $urandom_range(66, 72);
    end else if ($urandom_range(9) == 0) begin
      plen = $urandom_range(9, 40);
    end else begin
      plen = $urandom_range(1, 6);
    end
    for (int i = 0; i < plen; i++) pat_syms[i] = alpha[$urandom_range(n_alpha - 1)];

    // Load the pattern; beats past the capacity are dropped by the block.
    send_beat(CMD_START, pat_syms[0]);
    for (int i = 1; i < plen; i++) send_beat(CMD_APPEND, pat_syms[i]);

    tlen = $urandom_range(8, 40);
    for (int t = 0; t < tlen && beats_sent < TOTAL_BEATS; t++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_beat(CMD_CODE(), SYM_W'($urandom_range(255)));
      end else if (pick < 22) begin
        for (int i = 0; i < plen && i < MAX_PATTERN; i++) send_beat(CMD_TEXT, pat_syms[i]);
      end else if (pick < 25) begin
        send_beat(CMD_APPEND, alpha[$urandom_range(n_alpha - 1)]);
      end else begin
        send_beat(CMD_TEXT, alpha[$urandom_range(n_alpha - 1)]);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Text before any pattern exists, then the unused command.
    send_beat(CMD_TEXT, 8'h41);
    send_beat(CMD_UNUSED, 8'hFF);
    // Append to an empty pattern acts as a start but keeps the position.
    send_beat(CMD_APPEND, 8'h61);
    send_beat(CMD_TEXT, 8'h61);
    // Growing the pattern in the middle of the text keeps the match state.
    send_beat(CMD_APPEND, 8'h62);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h62);
    send_beat(CMD_TEXT, 8'h62);
    // Extreme symbols and overlapping matches of a self-bordered pattern.
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_UNUSED, 8'h00);
    // A mismatch that needs a fallback walk.
    send_beat(CMD_START, 8'h61);
    send_beat(CMD_APPEND, 8'h61);
    send_beat(CMD_APPEND, 8'h62);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h62);

    // The first random session always overfills the pattern.
    run_pattern_session(1'b1);
    while (beats_sent < TOTAL_BEATS) run_pattern_session(1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(20_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/kmp_pkg.sv
rtl/kmp_front.sv
rtl/kmp_back.sv
rtl/kmp_stream_matcher.sv
rtl/kmp_checker.sv
tb/kmp_match_checker.sv
tb/tb_kmp_stream_matcher.sv
